@@ rtl/swrp_pkg.sv @@
// Package for the sliding window rate policer.
// Field widths, register map, sequencer states and shared constants.
// No dependencies.
package swrp_pkg;

	localparam int BYTES_W = 16;
	localparam int TIME_W  = 48;
	localparam int VERD_W  = 2;
	localparam int RATE_W  = 29;
	localparam int MAX_W   = 20;
	localparam int CFG_W   = 16;
	localparam int SUM_W   = 32;
	localparam int EFF_W   = 16;
	localparam int PROD_W  = SUM_W + 13;   // sum * 8000
	localparam int DEN_W   = EFF_W + 10;   // eff * 1000
	localparam int LIMIT_W = MAX_W + CFG_W - 8;
	localparam int TMO_W   = CFG_W + 10;   // timeout * 1000
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam int DEF_FIFO_DEPTH = 1024;

	localparam logic [MAX_W-1:0] RST_MAX_RATE  = '0;
	localparam logic [CFG_W-1:0] RST_WINDOW    = 16'd5000;
	localparam logic [CFG_W-1:0] RST_TOLERANCE = 16'd512;
	localparam logic [CFG_W-1:0] RST_TIMEOUT   = 16'd30;

	localparam logic [TIME_W:0]     MS_PER_SEC_T = 49'd1000;
	localparam logic [EFF_W-1:0]    MIN_EFF_MS   = 16'd1000;
	localparam logic [12:0]         BITS_X_MS    = 13'd8000;
	localparam logic [9:0]          MS_PER_SEC   = 10'd1000;
	localparam logic [RATE_W-1:0]   RATE_SAT     = '1;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MAX_RATE  = 2'd0;
	localparam logic [1:0] REG_WINDOW    = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;
	localparam logic [1:0] REG_TIMEOUT   = 2'd3;

	typedef enum logic [VERD_W-1:0] {
		VERD_OK         = 2'd0,
		VERD_VIOLATION  = 2'd1,
		VERD_DISCONNECT = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OVF_RD,
		ST_OVF_POP,
		ST_PUSH,
		ST_RD,
		ST_CHK,
		ST_EFF,
		ST_MUL,
		ST_DIV,
		ST_VERD,
		ST_OFF
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quo;
	} div_rsp_t;

endpackage

@@ rtl/swrp_if.sv @@
// Request channel interfaces of the rate policer: packets in, results out.
// Depends on swrp_pkg.
interface swrp_pkt_if import swrp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] packet_bytes;
	logic [TIME_W-1:0]  now_ms;

	modport source (output valid, packet_bytes, now_ms, input ready);
	modport sink   (input valid, packet_bytes, now_ms, output ready);
endinterface

interface swrp_res_if import swrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VERD_W-1:0] verdict;
	logic [RATE_W-1:0] rate_kbps;
	logic              overflow;

	modport source (output valid, verdict, rate_kbps, overflow, input ready);
	modport sink   (input valid, verdict, rate_kbps, overflow, output ready);
endinterface

@@ rtl/sliding_window_rate_policer_top.sv @@
// Sliding window rate policer: packets in (bytes, ms timestamp), one verdict per packet.
//
// Channels: pkt (valid/ready, packet_bytes, now_ms) and res (valid/ready, verdict,
// rate_kbps, overflow). An APB port sets max rate, window, spike tolerance and timeout.
// Packets go into a FIFO RAM of (time, bytes) entries; a small sequencer walks the
// entries to expire the old ones and then runs the rate division on the
// bit-serial divider (swrp_div).
// Each expired entry costs one ST_RD/ST_CHK pass, and a full FIFO first evicts its
// oldest entry in ST_OVF_RD/ST_OVF_POP; the 45-step divider dominates. With the
// limit at zero no division runs. One packet is in flight at a time;
// pkt.ready is high only while the sequencer is idle, so a new packet is taken only
// once the previous one's result has been loaded into the output register.
// The result sits in an output register; a stalled receiver holds the sequencer
// in its final step until the register frees, while that held result does not
// block accepting the next packet.
// Reset (arst_n, asynchronous) empties the FIFO, clears the byte sum and the
// violation state and loads the register defaults; no memory clearing pass.
module sliding_window_rate_policer_top import swrp_pkg::*; #(
	parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	swrp_pkt_if.sink          pkt,
	swrp_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = AW + 1;
	localparam int EW = TIME_W + BYTES_W;

	// configuration
	logic [MAX_W-1:0] max_rate_q;
	logic [CFG_W-1:0] window_q, tol_q, timeout_q;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q <= RST_MAX_RATE;
			window_q   <= RST_WINDOW;
			tol_q      <= RST_TOLERANCE;
			timeout_q  <= RST_TIMEOUT;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MAX_RATE:  max_rate_q <= pwdata[MAX_W-1:0];
				REG_WINDOW:    window_q   <= pwdata[CFG_W-1:0];
				REG_TOLERANCE: tol_q      <= pwdata[CFG_W-1:0];
				REG_TIMEOUT:   timeout_q  <= pwdata[CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_RATE:  prdata = APB_DW'(max_rate_q);
			REG_WINDOW:    prdata = APB_DW'(window_q);
			REG_TOLERANCE: prdata = APB_DW'(tol_q);
			REG_TIMEOUT:   prdata = APB_DW'(timeout_q);
			default:       prdata = '0;
		endcase
	end

	// sequencer and datapath state
	state_t state_q, state_d;

	logic [AW-1:0]        head_q, tail_q;
	logic [CW-1:0]        count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TIME_W-1:0]    last_clean_q;
	logic                 viol_q;
	logic [TIME_W-1:0]    vbegin_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [TIME_W-1:0]    now_q;
	logic                 ovf_q;
	logic                 clean_q;
	logic                 front_vld_q;
	logic [TIME_W-1:0]    front_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [TMO_W-1:0]     tmo_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DEN_W-1:0]     den_q;

	logic                 res_valid_q;
	verdict_t             verdict_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 res_ovf_q;

	// RAM and divider hookup
	logic                 ram_we;
	logic [EW-1:0]        ram_rdata;
	logic [TIME_W-1:0]    rd_time;
	logic [BYTES_W-1:0]   rd_size;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign rd_time = ram_rdata[EW-1:BYTES_W];
	assign rd_size = ram_rdata[BYTES_W-1:0];

	swrp_ram #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({now_q, bytes_q}),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	swrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// combinational helpers
	logic                 slot_free;
	logic                 expired;
	logic                 clean_due;
	logic [TIME_W-1:0]    age;
	logic [EFF_W-1:0]     eff_d;
	logic                 exceed;
	logic [TIME_W:0]      deadline;
	verdict_t             verdict_d;
	logic [AW-1:0]        head_nx, tail_nx;

	assign slot_free = !res_valid_q || res.ready;
	assign expired   = ({1'b0, rd_time} + {{(TIME_W+1-CFG_W){1'b0}}, window_q})
	                   < {1'b0, now_q};
	assign clean_due = {1'b0, now_q} > ({1'b0, last_clean_q} + MS_PER_SEC_T);
	assign age       = now_q - front_q;
	assign head_nx   = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	always_comb begin
		eff_d = window_q;
		if (front_vld_q) begin
			if (now_q < front_q) begin
				eff_d = MIN_EFF_MS;
			end else if (age < TIME_W'(window_q)) begin
				eff_d = (age < TIME_W'(MIN_EFF_MS)) ? MIN_EFF_MS : age[EFF_W-1:0];
			end
		end
		if (eff_d == '0) begin
			eff_d = EFF_W'(1);
		end
	end

	assign exceed   = div_rsp.quo > PROD_W'(limit_q);
	assign deadline = {1'b0, (viol_q ? vbegin_q : now_q)} + (TIME_W+1)'(tmo_q);

	always_comb begin
		if (!exceed) begin
			verdict_d = VERD_OK;
		end else if ({1'b0, now_q} >= deadline) begin
			verdict_d = VERD_DISCONNECT;
		end else begin
			verdict_d = VERD_VIOLATION;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pkt.valid) begin
					state_d = (count_q >= CW'(FIFO_DEPTH)) ? ST_OVF_RD : ST_PUSH;
				end
			end
			ST_OVF_RD:  state_d = ST_OVF_POP;
			ST_OVF_POP: state_d = ST_PUSH;
			ST_PUSH:    state_d = ST_RD;
			ST_RD:      state_d = ST_CHK;
			ST_CHK: begin
				if (clean_q && count_q != '0 && expired) begin
					state_d = ST_RD;
				end else begin
					state_d = (max_rate_q == '0) ? ST_OFF : ST_EFF;
				end
			end
			ST_EFF:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_VERD;
				end
			end
			ST_VERD, ST_OFF: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pkt.ready     = 1'b0;
		ram_we        = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = prod_q;
		div_req.den   = den_q;
		case (state_q)
			ST_IDLE: pkt.ready     = 1'b1;
			ST_PUSH: ram_we        = 1'b1;
			ST_MUL:  div_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			last_clean_q <= '0;
			viol_q       <= 1'b0;
			vbegin_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_OVF_POP: begin
					sum_q   <= sum_q - SUM_W'(rd_size);
					head_q  <= head_nx;
					count_q <= count_q - 1'b1;
				end
				ST_PUSH: begin
					tail_q  <= tail_nx;
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + SUM_W'(bytes_q);
					if (max_rate_q != '0 && clean_due) begin
						last_clean_q <= now_q;
					end
				end
				ST_CHK: begin
					if (clean_q && count_q != '0 && expired) begin
						sum_q   <= sum_q - SUM_W'(rd_size);
						head_q  <= head_nx;
						count_q <= count_q - 1'b1;
					end
				end
				ST_VERD: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						if (exceed) begin
							if (!viol_q) begin
								viol_q   <= 1'b1;
								vbegin_q <= now_q;
							end
						end else begin
							viol_q   <= 1'b0;
							vbegin_q <= '0;
						end
					end
				end
				ST_OFF: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bytes_q <= pkt.packet_bytes;
				now_q   <= pkt.now_ms;
				ovf_q   <= count_q >= CW'(FIFO_DEPTH);
			end
			ST_PUSH: clean_q <= (max_rate_q == '0) || clean_due;
			ST_CHK: begin
				front_vld_q <= count_q != '0;
				front_q     <= rd_time;
			end
			// divider operands settle here so the start in ST_MUL sees them
			ST_EFF: begin
				prod_q  <= PROD_W'(sum_q) * PROD_W'(BITS_X_MS);
				den_q   <= DEN_W'(eff_d) * DEN_W'(MS_PER_SEC);
				limit_q <= LIMIT_W'(((MAX_W+CFG_W)'(max_rate_q)
				           * (MAX_W+CFG_W)'(tol_q)) >> 8);
				tmo_q   <= TMO_W'(timeout_q) * TMO_W'(MS_PER_SEC);
			end
			ST_VERD: begin
				if (slot_free) begin
					verdict_q <= verdict_d;
					rate_q    <= (div_rsp.quo > PROD_W'(RATE_SAT)) ? RATE_SAT
					             : div_rsp.quo[RATE_W-1:0];
					res_ovf_q <= ovf_q;
				end
			end
			ST_OFF: begin
				if (slot_free) begin
					verdict_q <= VERD_OK;
					rate_q    <= '0;
					res_ovf_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid     = res_valid_q;
	assign res.verdict   = verdict_q;
	assign res.rate_kbps = rate_q;
	assign res.overflow  = res_ovf_q;
endmodule

@@ rtl/swrp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swrp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/swrp_div.sv @@
// Restoring divider, one quotient bit per cycle (PROD_W quotient bits per request).
// Depends on swrp_pkg.
module swrp_div import swrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

@@ sim/swrp_checker.sv @@
// Scoreboard for the sliding window rate policer: mirrors the APB register writes,
// predicts one result per accepted packet request and compares the result channel.
// Depends on swrp_pkg and the swrp_pkt_if / swrp_res_if interfaces.
`timescale 1ns / 100ps
module swrp_checker import swrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	swrp_pkt_if               pkt,
	swrp_res_if               res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                errors,
	output int                pending
);

	localparam int DEPTH = DEF_FIFO_DEPTH;

	typedef struct packed {
		verdict_t          verdict;
		logic [RATE_W-1:0] rate_kbps;
		logic              overflow;
	} policer_res_t;

	policer_res_t verdict_q[$];

	// register shadow
	logic [MAX_W-1:0] lim_kbps;
	logic [CFG_W-1:0] win_ms;
	logic [CFG_W-1:0] tol_q8;
	logic [CFG_W-1:0] tmo_s;

	// window FIFO shadow
	logic [TIME_W-1:0]  stamp_mem [DEPTH];
	logic [BYTES_W-1:0] size_mem [DEPTH];
	int unsigned        head, tail, count;
	logic [SUM_W-1:0]   byte_sum;
	longint unsigned    last_sweep, viol_start, total_bytes;
	logic               in_viol;

	task automatic drop_oldest();
		byte_sum = byte_sum - size_mem[head];
		head = (head + 1 >= DEPTH) ? 0 : head + 1;
		count--;
	endtask

	task automatic expire_old(longint unsigned now);
		while (count != 0 && longint'(stamp_mem[head]) + longint'(win_ms) < now)
			drop_oldest();
	endtask

	task automatic police_packet(logic [BYTES_W-1:0] nbytes, logic [TIME_W-1:0] stamp);
		longint unsigned now, eff, rate, lmt, front;
		policer_res_t r;
		now = stamp;
		r.overflow = 1'b0;
		total_bytes += nbytes;
		if (count >= DEPTH) begin
			drop_oldest();
			r.overflow = 1'b1;
		end
		stamp_mem[tail] = stamp;
		size_mem[tail] = nbytes;
		tail = (tail + 1 >= DEPTH) ? 0 : tail + 1;
		count++;
		byte_sum = byte_sum + nbytes;
		if (lim_kbps == '0) begin
			expire_old(now);
			r.verdict = VERD_OK;
			r.rate_kbps = '0;
			verdict_q.push_back(r);
			return;
		end
		if (now > last_sweep + 1000) begin
			expire_old(now);
			last_sweep = now;
		end
		eff = win_ms;
		if (count != 0) begin
			front = stamp_mem[head];
			if (now < front)
				eff = 1000;
			else if (now - front < longint'(win_ms))
				eff = (now - front < 1000) ? 1000 : now - front;
		end
		if (eff == 0)
			eff = 1;
		rate = (longint'(byte_sum) * 8000 / eff) / 1000;
		lmt = (longint'(lim_kbps) * longint'(tol_q8)) >> 8;
		if (rate > lmt) begin
			if (!in_viol) begin
				in_viol = 1'b1;
				viol_start = now;
			end
			r.verdict = (now >= viol_start + longint'(tmo_s) * 1000) ? VERD_DISCONNECT
				: VERD_VIOLATION;
		end else begin
			in_viol = 1'b0;
			viol_start = 0;
			r.verdict = VERD_OK;
		end
		r.rate_kbps = (rate > longint'(RATE_SAT)) ? RATE_SAT : rate[RATE_W-1:0];
		verdict_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		policer_res_t want;
		if (!arst_n) begin
			lim_kbps = RST_MAX_RATE;
			win_ms = RST_WINDOW;
			tol_q8 = RST_TOLERANCE;
			tmo_s = RST_TIMEOUT;
			head = 0;
			tail = 0;
			count = 0;
			byte_sum = '0;
			last_sweep = 0;
			viol_start = 0;
			total_bytes = 0;
			in_viol = 1'b0;
			verdict_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MAX_RATE:  lim_kbps = pwdata[MAX_W-1:0];
					REG_WINDOW:    win_ms = pwdata[CFG_W-1:0];
					REG_TOLERANCE: tol_q8 = pwdata[CFG_W-1:0];
					REG_TIMEOUT:   tmo_s = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (pkt.valid && pkt.ready)
				police_packet(pkt.packet_bytes, pkt.now_ms);
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual verdict %0d rate %0d ovf %0d",
						$time, res.verdict, res.rate_kbps, res.overflow);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (res.verdict !== want.verdict) begin
						$display("%0t: verdict mismatch: expected %0d, actual %0d",
							$time, want.verdict, res.verdict);
						errors++;
					end
					if (res.rate_kbps !== want.rate_kbps) begin
						$display("%0t: rate_kbps mismatch: expected %0d, actual %0d",
							$time, want.rate_kbps, res.rate_kbps);
						errors++;
					end
					if (res.overflow !== want.overflow) begin
						$display("%0t: overflow mismatch: expected %0d, actual %0d",
							$time, want.overflow, res.overflow);
						errors++;
					end
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

@@ sim/tb_sliding_window_rate_policer_top.sv @@
// Top of the rate policer testbench: clock, reset, APB setup, packet requests and
// result back-pressure; verdict from the swrp_checker failure count.
// Depends on swrp_pkg, swrp_if.sv, swrp_checker.sv and the policer RTL.
`timescale 1ns / 100ps
module tb_sliding_window_rate_policer_top;
	import swrp_pkg::*;

	localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                errors, pending;

	logic              no_idle;
	logic              hold_req;
	longint unsigned   cur_ms;

	swrp_pkt_if pkt_ch ();
	swrp_res_if res_ch ();

	sliding_window_rate_policer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	swrp_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// result side back-pressure, plus one long hold when asked
	initial begin
		int n;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = idle_len();
				if (n == 0) begin
					res_ch.ready <= 1'b1;
				end else begin
					res_ch.ready <= 1'b0;
					repeat (n - 1) @(posedge clk);
				end
			end
		end
	end

	task automatic send_packet(logic [BYTES_W-1:0] nbytes, longint unsigned ms);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.packet_bytes <= nbytes;
		pkt_ch.now_ms <= ms[TIME_W-1:0];
		do @(posedge clk); while (!pkt_ch.ready);
	endtask

	task automatic drain();
		pkt_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(int rate, int win, int tol, int tmo);
		drain();
		reg_write(REG_MAX_RATE, rate);
		reg_write(REG_WINDOW, win);
		reg_write(REG_TOLERANCE, tol);
		reg_write(REG_TIMEOUT, tmo);
	endtask

	// random traffic: mostly forward steps, some jumps past the window, a few steps back
	task automatic run_traffic(int n, int step_max, int bytes_max, int win);
		int r;
		logic [BYTES_W-1:0] nb;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				cur_ms -= (cur_ms < 2000) ? cur_ms : $urandom_range(0, 2000);
			else if (r < 8)
				cur_ms += win + $urandom_range(0, 3000);
			else
				cur_ms += $urandom_range(0, step_max);
			r = $urandom_range(0, 19);
			nb = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0
				: BYTES_W'($urandom_range(0, bytes_max));
			send_packet(nb, cur_ms);
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pkt_ch.valid = 1'b0;
		pkt_ch.packet_bytes = '0;
		pkt_ch.now_ms = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		cur_ms = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limiting off at reset: rate zero, expiry every packet, time going back
		send_packet(16'h0, 0);
		send_packet(16'hFFFF, 0);
		send_packet(16'hFFFF, 1);
		send_packet(16'd100, 5000);
		send_packet(16'd1, 9000);
		send_packet(16'd7, 4000);

		// ok, violation, then disconnect after one second, then back to ok
		setup(100, 1000, 256, 1);
		send_packet(16'd2000, 10000);
		send_packet(16'hFFFF, 10010);
		send_packet(16'hFFFF, 10500);
		send_packet(16'hFFFF, 11010);
		send_packet(16'd10, 20000);
		send_packet(16'd10, 23000);

		// zero timeout disconnects at once; zero window
		setup(1, 0, 256, 0);
		send_packet(16'hFFFF, 30000);
		send_packet(16'd1, 30000);
		send_packet(16'h0, 40000);
		cur_ms = 40000;

		setup(1048575, 65535, 65535, 65535);
		run_traffic(60, 60, 65535, 65535);
		setup(1, 1, 256, 0);
		no_idle = 1'b1;
		run_traffic(60, 60, 65535, 1);
		no_idle = 1'b0;
		setup(50, 0, 300, 1);
		run_traffic(40, 1500, 65535, 0);

		// fill the FIFO past its depth, first unlimited, then with a limit
		setup(0, 65535, 512, 30);
		cur_ms += 70000;
		run_traffic(1030, 1, 65535, 65535);
		setup(20000, 65535, 512, 30);
		run_traffic(40, 1, 65535, 65535);

		for (int p = 0; p < 6; p++) begin
			int win;
			win = $urandom_range(1, 20000);
			setup($urandom_range(500, 80000), win, $urandom_range(256, 2048),
				$urandom_range(0, 3));
			no_idle = (p == 3);
			hold_req = (p == 2);
			run_traffic(80, 60, 65535, win);
		end
		no_idle = 1'b0;

		// top of the timestamp range
		setup(5000, 10000, 256, 2);
		cur_ms = TIME_MAX - 38000;
		for (int i = 0; i < 20; i++) begin
			cur_ms = (cur_ms + 2000 > TIME_MAX) ? TIME_MAX : cur_ms + 2000;
			send_packet(BYTES_W'($urandom_range(0, 65535)), cur_ms);
		end

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
